// ===== design/lwedec_pkg.sv =====
package lwedec_pkg;

   // Sizes of the key store and of the ciphertext modulus q = 2^MOD_BITS
   localparam int KEY_LEN  = 512;
   localparam int MOD_BITS = 9;
   localparam int KEY_AW   = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

   // Fixed port widths
   localparam int IDX_W  = 9;
   localparam int VAL_W  = 9;
   localparam int MSG_W  = 9;
   localparam int PM_W   = 10;
   localparam int OFS_W  = 9;
   localparam int CSR_IW = 1;
   localparam int CSR_DW = 10;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_KEY  = 2'd0,
      KIND_BODY = 2'd1,
      KIND_MASK = 2'd2
   } kind_type;

   // Register indexes
   localparam logic [CSR_IW-1:0] CSR_PLAIN_MOD = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_ROUND_OFS = 1'd1;

   // Request held for the cycle in which the key word comes out of the store
   typedef struct packed {
      logic                body;
      logic                mask;
      logic                last;
      logic                in_range;
      logic [MOD_BITS-1:0] value;
   } stage_type;

endpackage

// ===== design/lwedec_ram.sv =====
module lwedec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lwedec_mac.sv =====
module lwedec_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  lwedec_pkg::stage_type         stage,
   input  logic [lwedec_pkg::MOD_BITS-1:0] key_data,
   output logic [lwedec_pkg::MOD_BITS-1:0] acc,
   output logic                          fin
);

   import lwedec_pkg::*;

   logic [MOD_BITS-1:0]   acc_ff, acc_in;
   logic                  fin_ff, fin_in;
   logic [MOD_BITS-1:0]   key_word;
   logic [2*MOD_BITS-1:0] product;

   // Key word of an out-of-range mask counts as zero
   assign key_word = stage.in_range ? key_data : '0;
   assign product  = (2*MOD_BITS)'(stage.value) * (2*MOD_BITS)'(key_word);

   // Accumulator update, mod q by truncation
   always_comb begin
      acc_in = acc_ff;
      priority if (stage.body) begin
         acc_in = stage.value;
      end else if (stage.mask) begin
         acc_in = acc_ff - product[MOD_BITS-1:0];
      end
      fin_in = stage.mask && stage.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         fin_ff <= fin_in;
      end
   end

   assign acc = acc_ff;
   assign fin = fin_ff;

endmodule

// ===== design/lwe_decrypt_inner_product.sv =====
// LWE decryption by streamed inner product, modulus q = 2^MOD_BITS.
// Request channel: a request is taken at a clock edge with start high and
// busy low. busy stays low, so one request can be taken every cycle.
// Kind key writes value mod q into the key store at index; kind body loads
// the accumulator; kind mask subtracts value times the stored key word.
// A mask with last set produces one message on rsp_message, marked by
// rsp_valid for a single cycle.
// The receiver cannot stall; every message must be taken when strobed.
// Rate: one request per cycle. A request reads the key store in its own
// cycle, the multiply-subtract uses the registered read data in the next,
// and the final scaling multiply works on the registered accumulator.
// Registers (csr_ channel, always ready): index 0 plain modulus (reset 4),
// index 1 rounding offset (reset 64); write them only while idle.
// Synchronous reset clears accumulator and pipeline and resets the registers.
// The key store is not cleared: read only entries that have been loaded.
module lwe_decrypt_inner_product (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_kind,
   input  logic [lwedec_pkg::IDX_W-1:0]    req_index,
   input  logic [lwedec_pkg::VAL_W-1:0]    req_value,
   input  logic                            req_last,
   output logic                            rsp_valid,
   output logic [lwedec_pkg::MSG_W-1:0]    rsp_message,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lwedec_pkg::CSR_IW-1:0]   csr_index,
   input  logic [lwedec_pkg::CSR_DW-1:0]   csr_data
);

   import lwedec_pkg::*;

   logic                   req_accept;
   logic                   in_range;
   logic [KEY_AW-1:0]      key_addr;
   logic [MOD_BITS-1:0]    value_q;
   logic                   key_wr;
   stage_type              stage_ff, stage_in;
   logic [MOD_BITS-1:0]    key_data;
   logic [MOD_BITS-1:0]    acc;
   logic                   fin;
   logic [PM_W-1:0]        plain_mod_ff;
   logic [OFS_W-1:0]       round_ofs_ff;
   logic [MOD_BITS-1:0]    rounded;
   logic [MOD_BITS+PM_W-1:0] scaled;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MSG_W-1:0]       rsp_message_ff, rsp_message_in;

   // Request decode
   assign busy       = 1'b0;
   assign req_accept = start && !busy;
   assign in_range   = 32'(req_index) < KEY_LEN;
   assign key_addr   = KEY_AW'(req_index);
   assign value_q    = MOD_BITS'(req_value);

   always_comb begin
      stage_in = '0;
      key_wr   = 1'b0;
      if (req_accept) begin
         unique case (req_kind)
            KIND_KEY:  key_wr = in_range;
            KIND_BODY: stage_in.body = 1'b1;
            KIND_MASK: stage_in.mask = 1'b1;
            default:   stage_in = '0;
         endcase
      end
      stage_in.last     = req_last;
      stage_in.in_range = in_range;
      stage_in.value    = value_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // Key store; a write is visible to a read in the following cycle
   lwedec_ram #(
      .WIDTH (MOD_BITS),
      .DEPTH (KEY_LEN)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (key_addr),
      .wr_data (value_q),
      .rd_addr (key_addr),
      .rd_data (key_data)
   );

   lwedec_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage_ff),
      .key_data (key_data),
      .acc      (acc),
      .fin      (fin)
   );

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_mod_ff <= PM_W'(4);
         round_ofs_ff <= OFS_W'(64);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PLAIN_MOD: plain_mod_ff <= PM_W'(csr_data);
            CSR_ROUND_OFS: round_ofs_ff <= OFS_W'(csr_data);
            default:       plain_mod_ff <= plain_mod_ff;
         endcase
      end
   end

   // Rounding and scaling: top bits of ((acc + offset) mod q) * t
   assign rounded        = acc + MOD_BITS'(round_ofs_ff);
   assign scaled         = (MOD_BITS+PM_W)'(rounded) * (MOD_BITS+PM_W)'(plain_mod_ff);
   assign rsp_message_in = MSG_W'(scaled >> MOD_BITS);
   assign rsp_valid_in   = fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_message_ff <= rsp_message_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_message = rsp_message_ff;

`ifndef ASSERT_OFF
   // A message only follows an earlier last mask request
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept && req_kind == KIND_MASK && req_last, 3))
      else $error("message without a last mask request");

   // A body request loads its value into the accumulator
   a_body_load: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_BODY) |-> ##2 (acc == $past(value_q, 2)))
      else $error("accumulator not loaded from body");

   // A last mask request always yields a message
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_MASK && req_last) |-> ##3 rsp_valid)
      else $error("last mask request without message");
`endif

endmodule

// ===== tb/sv/lwe_decrypt_inner_product_tb.sv =====
module lwe_decrypt_inner_product_tb;

   import lwedec_pkg::*;

   localparam logic [1:0]       KIND_SPARE   = 2'd3;   // unused kind, dropped by the block
   localparam int               ITEM_TARGET  = 1450;
   localparam int               N_PHASES     = 8;
   localparam int               DRAIN_CYCLES = 6;      // pipeline depth plus margin
   localparam int               TAIL_CYCLES  = 8;
   localparam int               STALL_LIMIT  = 2000;
   localparam logic [VAL_W-1:0] VAL_MAX      = '1;

   // One pending step: a request or a register write
   typedef struct {
      bit                 is_write;
      logic [1:0]         kind;
      logic [IDX_W-1:0]   index;
      logic [VAL_W-1:0]   value;
      logic               last;
      logic [CSR_IW-1:0]  reg_idx;
      logic [CSR_DW-1:0]  reg_data;
   } lwe_op_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   logic [1:0]         req_kind    = '0;
   logic [IDX_W-1:0]   req_index   = '0;
   logic [VAL_W-1:0]   req_value   = '0;
   logic               req_last    = 1'b0;
   logic               rsp_valid;
   logic [MSG_W-1:0]   rsp_message;
   logic               csr_valid   = 1'b0;
   logic               csr_ready;
   logic [CSR_IW-1:0]  csr_index   = '0;
   logic [CSR_DW-1:0]  csr_data    = '0;

   lwe_op_type         pending_ops[$];
   logic [MSG_W-1:0]   owed_messages[$];

   // Predictor state
   logic [MOD_BITS-1:0] key_mem [KEY_LEN];
   logic [MOD_BITS-1:0] acc_model = '0;
   logic [PM_W-1:0]     pm_model  = 10'd4;
   logic [OFS_W-1:0]    ofs_model = 9'd64;

   // Stimulus bookkeeping: which key entries have been loaded so far
   bit                  key_loaded [KEY_LEN];
   int                  loaded_idx[$];
   int                  items_n;

   // Driver state
   int                  quiet_n;
   int                  idle_gap;
   int                  run_left;
   bit                  answers_settled = 1'b1;
   int                  stall_n;
   int                  err_n;

   lwe_decrypt_inner_product u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_index   (req_index),
      .req_value   (req_value),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_message (rsp_message),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Model of each accepted request, in order; a last mask owes a message
   task automatic decrypt_predict(input lwe_op_type op);
      logic [2*VAL_W-1:0]       prod;
      logic [MOD_BITS-1:0]      key_word;
      logic [MOD_BITS-1:0]      rounded;
      logic [MOD_BITS+PM_W-1:0] scaled;
      case (op.kind)
         KIND_KEY: if (op.index < KEY_LEN) key_mem[op.index] = op.value[MOD_BITS-1:0];
         KIND_BODY: acc_model = op.value[MOD_BITS-1:0];
         KIND_MASK: begin
            key_word  = (op.index < KEY_LEN) ? key_mem[op.index] : '0;
            prod      = op.value * key_word;
            acc_model = acc_model - prod[MOD_BITS-1:0];
            if (op.last) begin
               rounded = acc_model + ofs_model[MOD_BITS-1:0];
               scaled  = rounded * pm_model;
               owed_messages.push_back(scaled[MOD_BITS +: MSG_W]);
            end
         end
         default: ;
      endcase
   endtask

   task automatic apply_csr(input lwe_op_type op);
      if (op.reg_idx == CSR_PLAIN_MOD) pm_model = op.reg_data[PM_W-1:0];
      else if (op.reg_idx == CSR_ROUND_OFS) ofs_model = op.reg_data[OFS_W-1:0];
   endtask

   // Mostly back-to-back or short gaps, now and then a long one,
   // with occasional runs of no gaps at all
   function automatic int draw_gap();
      int r;
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         run_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic logic [VAL_W-1:0] draw_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return VAL_MAX;
      return VAL_W'($urandom_range(0, VAL_MAX));
   endfunction

   task automatic queue_request(input logic [1:0] kind, input int index,
                                input logic [VAL_W-1:0] value, input logic last);
      lwe_op_type op;
      op          = '{default: '0};
      op.kind     = kind;
      op.index    = IDX_W'(index);
      op.value    = value;
      op.last     = last;
      pending_ops.push_back(op);
      items_n++;
      if (kind == KIND_KEY && index < KEY_LEN && !key_loaded[index]) begin
         key_loaded[index] = 1'b1;
         loaded_idx.push_back(index);
      end
   endtask

   task automatic queue_write(input logic [CSR_IW-1:0] idx, input int data);
      lwe_op_type op;
      op          = '{default: '0};
      op.is_write = 1'b1;
      op.reg_idx  = idx;
      op.reg_data = CSR_DW'(data);
      pending_ops.push_back(op);
   endtask

   function automatic int pick_loaded();
      return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
   endfunction

   // One ciphertext: body, then masks over loaded key entries, last on the final one.
   // Now and then a key entry is reloaded mid-stream and used straight away.
   task automatic queue_ciphertext();
      int r;
      int n_masks;
      int idx;
      r = $urandom_range(0, 99);
      if (r < 70) n_masks = $urandom_range(1, 4);
      else if (r < 95) n_masks = $urandom_range(5, 16);
      else n_masks = $urandom_range(17, 64);
      queue_request(KIND_BODY, 0, draw_value(), 1'($urandom_range(0, 1)));
      for (int m = 0; m < n_masks; m++) begin
         idx = pick_loaded();
         if ($urandom_range(0, 9) == 0) queue_request(KIND_KEY, idx, draw_value(), 1'b0);
         queue_request(KIND_MASK, idx, draw_value(), m == n_masks - 1);
      end
   endtask

   // Key loads, well-formed ciphertexts with random content, plus stray and unused requests
   task automatic queue_phase(input int quota);
      int stop_at;
      int r;
      stop_at = items_n + quota;
      while (items_n < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 12)
            queue_request(KIND_KEY, $urandom_range(0, KEY_LEN - 1), draw_value(),
                          1'($urandom_range(0, 1)));
         else if (r < 80)
            queue_ciphertext();
         else if (r < 88)
            queue_request(KIND_MASK, pick_loaded(), draw_value(),
                          1'($urandom_range(0, 1)));
         else if (r < 93)
            queue_request(KIND_BODY, $urandom_range(0, KEY_LEN - 1), draw_value(),
                          1'($urandom_range(0, 1)));
         else
            queue_request(KIND_SPARE, $urandom_range(0, KEY_LEN - 1), draw_value(),
                          1'($urandom_range(0, 1)));
      end
   endtask

   // Driver: retire what the edge took, then present the next step
   always @(posedge clock) begin : drive_proc
      lwe_op_type       head;
      logic             nx_start;
      logic             nx_csr_valid;
      logic [1:0]       nx_kind;
      logic [IDX_W-1:0] nx_index;
      logic [VAL_W-1:0] nx_value;
      logic             nx_last;
      logic [CSR_IW-1:0] nx_reg_idx;
      logic [CSR_DW-1:0] nx_reg_data;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         quiet_n   = DRAIN_CYCLES;
         idle_gap  = 0;
         run_left  = 0;
      end else begin
         nx_start     = start;
         nx_csr_valid = csr_valid;
         nx_kind      = req_kind;
         nx_index     = req_index;
         nx_value     = req_value;
         nx_last      = req_last;
         nx_reg_idx   = csr_index;
         nx_reg_data  = csr_data;

         if (start && !busy) begin
            head = pending_ops.pop_front();
            decrypt_predict(head);
            nx_start = 1'b0;
            quiet_n  = 0;
            idle_gap = draw_gap();
         end else if (quiet_n < DRAIN_CYCLES) begin
            quiet_n++;
         end

         if (csr_valid && csr_ready) begin
            head = pending_ops.pop_front();
            apply_csr(head);
            nx_csr_valid = 1'b0;
         end

         if (!nx_start && !nx_csr_valid && pending_ops.size() != 0) begin
            head = pending_ops[0];
            if (head.is_write) begin
               // registers change only once the pipeline has emptied
               if (quiet_n >= DRAIN_CYCLES && answers_settled) begin
                  nx_csr_valid = 1'b1;
                  nx_reg_idx   = head.reg_idx;
                  nx_reg_data  = head.reg_data;
               end
            end else if (idle_gap > 0) begin
               idle_gap--;
            end else begin
               nx_start = 1'b1;
               nx_kind  = head.kind;
               nx_index = head.index;
               nx_value = head.value;
               nx_last  = head.last;
            end
         end

         start     <= nx_start;
         csr_valid <= nx_csr_valid;
         req_kind  <= nx_kind;
         req_index <= nx_index;
         req_value <= nx_value;
         req_last  <= nx_last;
         csr_index <= nx_reg_idx;
         csr_data  <= nx_reg_data;
      end
   end

   // Sampled between edges so the driver sees a settled value
   always @(negedge clock) answers_settled <= (owed_messages.size() == 0);

   // Monitor: each strobed message against the oldest expectation
   always @(posedge clock) begin : check_proc
      logic [MSG_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (owed_messages.size() == 0) begin
            $display("%0t unexpected message: expected none, actual %0d", $time, rsp_message);
            err_n++;
         end else begin
            want = owed_messages.pop_front();
            if (rsp_message !== want) begin
               $display("%0t message mismatch: expected %0d, actual %0d",
                        $time, want, rsp_message);
               err_n++;
            end
         end
      end
   end

   // Watchdog on cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
         stall_n <= 0;
      end else if (stall_n >= STALL_LIMIT) begin
         $display("** lwe_decrypt_inner_product: FAILED **");
         $finish;
      end else begin
         stall_n <= stall_n + 1;
      end
   end

   initial begin : stim_proc
      int pm_set  [N_PHASES];
      int ofs_set [N_PHASES];
      int quota;
      pm_set  = '{4, 2, 1, 512, 0, 1023, 0, 2};
      ofs_set = '{64, 128, 0, 511, 64, 255, 0, 64};
      pm_set[6]  = $urandom_range(0, (1 << PM_W) - 1);
      ofs_set[6] = $urandom_range(0, (1 << OFS_W) - 1);

      // Directed: field extremes, every kind, stray last flags, reused accumulator,
      // unused kind, key reload followed at once by a read of the same entry
      queue_request(KIND_KEY, 0, VAL_MAX, 1'b1);
      queue_request(KIND_KEY, KEY_LEN - 1, 0, 1'b0);
      queue_request(KIND_KEY, 170, 341, 1'b0);
      queue_request(KIND_KEY, 341, 170, 1'b0);
      queue_request(KIND_BODY, 0, VAL_MAX, 1'b1);
      queue_request(KIND_MASK, 0, VAL_MAX, 1'b0);
      queue_request(KIND_MASK, KEY_LEN - 1, VAL_MAX, 1'b0);
      queue_request(KIND_MASK, 170, 0, 1'b1);
      queue_request(KIND_SPARE, KEY_LEN - 1, VAL_MAX, 1'b1);
      queue_request(KIND_MASK, 341, 1, 1'b1);
      queue_request(KIND_BODY, 341, 0, 1'b0);
      queue_request(KIND_MASK, 0, 1, 1'b1);
      queue_request(KIND_BODY, 170, 256, 1'b0);
      queue_request(KIND_KEY, 0, 1, 1'b0);
      queue_request(KIND_MASK, 0, 256, 1'b1);
      queue_request(KIND_BODY, 0, 5, 1'b0);
      queue_request(KIND_MASK, 341, VAL_MAX, 1'b0);
      queue_request(KIND_MASK, 170, VAL_MAX, 1'b1);

      // Random phases, each under its own register setting; the first keeps reset values
      quota = (ITEM_TARGET - items_n) / N_PHASES;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph > 0) begin
            if (ph % 2 == 0) begin
               queue_write(CSR_PLAIN_MOD, pm_set[ph]);
               queue_write(CSR_ROUND_OFS, ofs_set[ph]);
            end else begin
               queue_write(CSR_ROUND_OFS, ofs_set[ph]);
               queue_write(CSR_PLAIN_MOD, pm_set[ph]);
            end
         end
         queue_phase(quota);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || owed_messages.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (err_n == 0) begin
         $display("** lwe_decrypt_inner_product: PASSED **");
      end else begin
         $display("** lwe_decrypt_inner_product: FAILED **");
      end
      $finish;
   end

endmodule

// ===== lwe_decrypt_inner_product.f =====
design/lwedec_pkg.sv
design/lwedec_ram.sv
design/lwedec_mac.sv
design/lwe_decrypt_inner_product.sv
tb/sv/lwe_decrypt_inner_product_tb.sv
